[hdl/spq_pkg.sv]
// Shared types and codes for the stable priority queue.
// Depends on nothing; every other file imports it.
package spq_pkg;

  // Request kinds carried on the input tuser
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes carried on the output tuser
  localparam logic [1:0] STAT_PUSHED    = 2'd0;
  localparam logic [1:0] STAT_POPPED    = 2'd1;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd2;
  localparam logic [1:0] STAT_PUSH_FULL = 2'd3;

  // One stored entry, urgency in the top bits
  typedef struct packed {
    logic [1:0]  urgency;
    logic [15:0] handle;
    logic [6:0]  age;
  } entry_t;

  // Controller state: no result held, or a result waiting on the output
  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic push;
    logic pop;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

[hdl/spq_ctrl.sv]
// Handshake controller for the stable priority queue.
// Depends on spq_pkg; drives commands into spq_datapath.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       kind,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a new transfer refills the output, a drain empties it
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (accept) begin
          state_next = S_HOLD;
        end else if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: take input while the result slot is free or being drained
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_HOLD: begin
        s_tready = m_tready;
        m_tvalid = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    cmd.load = accept;
    cmd.push = accept && (kind == KIND_PUSH) && !stat.full;
    cmd.pop  = accept && (kind == KIND_POP) && !stat.empty;
  end

endmodule

[hdl/spq_datapath.sv]
// Sorted slot row, fill count and result register of the priority queue.
// Depends on spq_pkg; commanded by spq_ctrl.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  logic       kind,
  input  entry_t     in_entry,
  output dp_stat_t   stat,
  output logic [1:0] res_status,
  output entry_t     res_entry,
  output logic [4:0] res_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [DEPTH-1:0] stay;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

  // Each cell keeps its entry when it is held and at least as urgent
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign stay[i] = (CW'(i) < count) && (slots[i].urgency <= in_entry.urgency);

    // Insert behind the stayers, shift the rest back; pop shifts forward
    always_ff @(posedge clk) begin
      if (cmd.push && !stay[i]) begin
        if (i == 0) begin
          slots[i] <= in_entry;
        end else begin
          slots[i] <= stay[(i == 0) ? 0 : i - 1] ? in_entry : slots[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.pop && (i < DEPTH - 1)) begin
        slots[i] <= slots[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Fill count update
  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Capture the result of each accepted transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_occupancy <= 5'(count_next);
      if (kind == KIND_PUSH) begin
        res_status <= stat.full ? STAT_PUSH_FULL : STAT_PUSHED;
        res_entry  <= '0;
      end else if (stat.empty) begin
        res_status <= STAT_POP_EMPTY;
        res_entry  <= '0;
      end else begin
        res_status <= STAT_POPPED;
        res_entry  <= slots[0];
      end
    end
  end

endmodule

[hdl/stable_priority_queue.sv]
// Top level of the stable priority queue: controller plus slot datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser is the kind (0 push, 1 pop),
//   s_tdata carries the pushed entry. Each request gives exactly one result
//   on the m_ stream: m_tuser is the status (pushed, popped, pop from empty,
//   push refused full), m_tdata the popped entry and the occupancy.
//   Entries stay sorted by urgency (0 most urgent); equal urgencies keep
//   arrival order. A push when full is dropped.
//   Latency: the result is valid the cycle after the request transfer.
//   Throughput: one request per cycle while the receiver takes results;
//   every slot compares its urgency with the new entry in parallel, so
//   insertion and removal each take a single shift of the slot row.
//   Reset empties the queue and drops m_tvalid; slot contents and the result
//   register are not cleared, the fill count alone marks slots valid.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken; it rises again in the cycle of that
//   transfer, so a new request may enter alongside.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [1:0] urgency, [17:2] payload_handle, [24:18] entry_age
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] out_urgency, [17:2] out_handle, [24:18] out_age,
                                 // [29:25] occupancy
  output logic [1:0]  m_tuser    // [1:0] status
);

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  entry_t     in_entry;
  entry_t     res_entry;
  logic [1:0] res_status;
  logic [4:0] res_occupancy;

  // Unpack the request payload
  assign in_entry.urgency = s_tdata[1:0];
  assign in_entry.handle  = s_tdata[17:2];
  assign in_entry.age     = s_tdata[24:18];

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (s_tuser),
    .in_entry      (in_entry),
    .stat          (stat),
    .res_status    (res_status),
    .res_entry     (res_entry),
    .res_occupancy (res_occupancy)
  );

  // Pack the result
  assign m_tdata = {2'b00, res_occupancy, res_entry.age, res_entry.handle, res_entry.urgency};
  assign m_tuser = res_status;

endmodule

[hdl/spq_checker.sv]
// Port-level checks for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue.
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Only a pop with data carries an entry
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_POPPED) |-> (m_tdata[24:0] == 25'd0))
    else $error("entry fields set on a result without data");

  // A refused push reports a full queue, an empty pop an empty one
  a_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == STAT_PUSH_FULL && m_tdata[29:25] != 5'(DEPTH)) ||
                 (m_tuser == STAT_POP_EMPTY && m_tdata[29:25] != 5'd0)) |-> 1'b0)
    else $error("occupancy disagrees with status");

  // Ready whenever no result is held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with free output");

  // Reset drops the output valid
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
